>>> hdl/bab_pkg.sv
package bab_pkg;

  localparam int BLOCK_SLOTS  = 64;
  localparam int REGION_SLOTS = 32;
  localparam int PAGE_BYTES   = 4096;
  localparam int BIDX_W = $clog2(BLOCK_SLOTS);
  localparam int RIDX_W = $clog2(REGION_SLOTS);
  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam logic [47:0] HEAP_BASE = 48'h100000;

  // config register byte addresses
  localparam logic [1:0] REG_MAX_ALLOC = 2'd0;

  typedef enum logic [2:0] {
    FN_MALLOC  = 3'd0,
    FN_ALIGNED = 3'd1,
    FN_CALLOC  = 3'd2,
    FN_REALLOC = 3'd3,
    FN_FREE    = 3'd4,
    FN_MMAP    = 3'd5,
    FN_MUNMAP  = 3'd6,
    FN_QUERY   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIZE     = 3'd1,
    ST_ALIGN    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_OVERLAP  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] address;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] alignment;
    logic        fixed_map;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] result_address;
    logic [31:0] block_size;
    logic [39:0] total_in_use;
    logic [39:0] peak_in_use;
  } rsp_t;

endpackage

>>> hdl/bump_allocator_with_block_table.sv
// channel   signals                                   notes
// request   start, busy, req                          beat taken when start & !busy
// response  done, rsp                                 one-cycle strobe, no backpressure
// config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
// The block table is walked one slot per cycle through a registered read, then the
// region table, then allocate, peak update and respond. calloc first runs a 32-step
// shift-add multiply; a calloc whose product is zero or oversized answers without
// either table scan.
// Alignment uses a mask (power of two).
// Reset clears valid bits and counters at once; no clearing pass.
// The receiver cannot stall; busy stays high until done.
module bump_allocator_with_block_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bab_pkg::req_t      req,
  output logic               done,
  output bab_pkg::rsp_t      rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHECK, S_BSCAN, S_RSCAN, S_OVL, S_ALLOC, S_MAP, S_DONE
  } state_t;

  state_t state;
  logic [31:0] size_limit;
  logic [47:0] next_free_address;
  logic [39:0] bytes_in_use, bytes_peak;

  logic [bab_pkg::BLOCK_SLOTS-1:0]  bvalid;
  logic [47:0] baddr [bab_pkg::BLOCK_SLOTS];
  logic [31:0] bsize [bab_pkg::BLOCK_SLOTS];
  logic [bab_pkg::REGION_SLOTS-1:0] rvalid;
  logic [47:0] raddr [bab_pkg::REGION_SLOTS];
  logic [31:0] rsize [bab_pkg::REGION_SLOTS];

  bab_pkg::req_t r;
  logic [bab_pkg::BIDX_W:0] bi;   // scan counter
  logic [bab_pkg::RIDX_W:0] ri;
  logic        bfree_ok, bhit_ok, rfree_ok, rhit_ok;
  logic [bab_pkg::BIDX_W-1:0] bfree, bhit;
  logic [bab_pkg::RIDX_W-1:0] rfree, rhit;
  logic [31:0] bhit_size;
  // registered block-table read, one slot behind the scan counter
  logic        bq_live, bq_valid;
  logic [bab_pkg::BIDX_W-1:0] bq_idx;
  logic [47:0] bq_addr;
  logic [31:0] bq_size;
  logic        grow;              // realloc moved the block; old one freed after peak
  logic [63:0] prod;              // count * size, shift-add
  logic [31:0] mcand;
  logic [5:0]  mstep;
  logic [32:0] eff_size;          // size to allocate
  logic [2:0]  status;
  logic [47:0] res_addr;
  logic [31:0] res_bsize;
  logic        ovl;

  assign pready = 1'b1;
  assign prdata = size_limit;
  assign busy   = (state != S_IDLE);

  bab_pkg::func_t fn;
  assign fn = bab_pkg::func_t'(r.func);

  // 49 bits so that rounding up near the top of the space is seen as overflow
  logic [48:0] align_mask, aligned_nf, page_nf, bump_a;
  logic [48:0] bump_end, fix_end;
  logic [32:0] pages;
  always_comb begin
    align_mask = {17'd0, r.alignment - 32'd1};
    aligned_nf = ({1'b0, next_free_address} + align_mask) & ~align_mask;
    page_nf    = ({1'b0, next_free_address} + 49'(bab_pkg::PAGE_BYTES - 1)) &
                 ~49'(bab_pkg::PAGE_BYTES - 1);
    pages      = ({1'b0, r.size} + 33'(bab_pkg::PAGE_BYTES - 1)) &
                 ~33'(bab_pkg::PAGE_BYTES - 1);
    bump_a     = (fn == bab_pkg::FN_ALIGNED) ? aligned_nf :
                 (fn == bab_pkg::FN_MMAP) ? page_nf : {1'b0, next_free_address};
    bump_end   = bump_a + 49'((fn == bab_pkg::FN_MMAP) ? pages : eff_size);
    fix_end    = {1'b0, r.address} + 49'(pages);
  end

  wire is_fixed = (fn == bab_pkg::FN_MMAP) && r.fixed_map && (r.address != '0);
  wire [bab_pkg::BIDX_W-1:0] bcur = bi[bab_pkg::BIDX_W-1:0];
  wire [bab_pkg::RIDX_W-1:0] rcur = ri[bab_pkg::RIDX_W-1:0];
  wire size_bad = (r.size == '0) || (r.size > size_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      size_limit <= '1;
      next_free_address <= bab_pkg::HEAP_BASE;
      bytes_in_use <= '0;
      bytes_peak <= '0;
      bvalid <= '0;
      rvalid <= '0;
    end else begin
      done <= (state == S_DONE);
      if (psel && penable && pwrite && paddr == bab_pkg::REG_MAX_ALLOC) size_limit <= pwdata;
      unique case (state)
        S_IDLE: if (start) begin
          r <= req;
          status <= bab_pkg::ST_OK;
          res_addr <= '0;
          res_bsize <= '0;
          bi <= '0; ri <= '0;
          bfree_ok <= 1'b0; bhit_ok <= 1'b0; rfree_ok <= 1'b0; rhit_ok <= 1'b0;
          bfree <= '0; bhit <= '0; rfree <= '0; rhit <= '0;
          bhit_size <= '0;
          bq_live <= 1'b0;
          grow <= 1'b0;
          ovl <= 1'b0;
          eff_size <= {1'b0, req.size};
          prod <= '0; mcand <= req.size; mstep <= '0;
          state <= (bab_pkg::func_t'(req.func) == bab_pkg::FN_CALLOC) ? S_MUL : S_BSCAN;
        end
        S_MUL: begin
          if (r.count[mstep[4:0]]) prod <= prod + ({32'd0, mcand} << mstep[4:0]);
          mstep <= mstep + 6'd1;
          if (mstep == 6'd31) state <= S_CHECK;
        end
        S_CHECK: begin
          if (prod == '0 || prod > {32'd0, size_limit}) begin
            status <= bab_pkg::ST_SIZE;
            state <= S_DONE;
          end else begin
            eff_size <= prod[32:0];
            state <= S_BSCAN;
          end
        end
        S_BSCAN: begin
          bq_addr  <= baddr[bcur];
          bq_size  <= bsize[bcur];
          bq_valid <= bvalid[bcur];
          bq_idx   <= bcur;
          bq_live  <= !bi[bab_pkg::BIDX_W];
          if (bq_live) begin
            if (!bq_valid && !bfree_ok) begin bfree_ok <= 1'b1; bfree <= bq_idx; end
            if (bq_valid && bq_addr == r.address && !bhit_ok) begin
              bhit_ok <= 1'b1; bhit <= bq_idx; bhit_size <= bq_size;
            end
          end
          bi <= bi + {{bab_pkg::BIDX_W{1'b0}}, 1'b1};
          if (bi[bab_pkg::BIDX_W]) state <= S_RSCAN;
        end
        S_RSCAN: begin
          if (!rvalid[rcur] && !rfree_ok) begin rfree_ok <= 1'b1; rfree <= rcur; end
          if (rvalid[rcur] && raddr[rcur] == r.address && !rhit_ok) begin
            rhit_ok <= 1'b1; rhit <= rcur;
          end
          if (rvalid[rcur] && {1'b0, raddr[rcur]} < fix_end &&
              {1'b0, r.address} < {1'b0, raddr[rcur]} + 49'(rsize[rcur])) ovl <= 1'b1;
          ri <= ri + {{bab_pkg::RIDX_W{1'b0}}, 1'b1};
          if (rcur == bab_pkg::RIDX_W'(bab_pkg::REGION_SLOTS - 1)) state <= S_ALLOC;
        end
        S_ALLOC: begin
          state <= S_MAP;
          case (fn)
            bab_pkg::FN_MALLOC, bab_pkg::FN_CALLOC, bab_pkg::FN_ALIGNED,
            bab_pkg::FN_REALLOC: begin
              if (fn == bab_pkg::FN_ALIGNED &&
                  (r.alignment == '0 || (r.alignment & (r.alignment - 32'd1)) != '0))
                status <= bab_pkg::ST_ALIGN;
              else if (fn == bab_pkg::FN_REALLOC && r.address != '0 && r.size == '0) begin
                if (!bhit_ok) status <= bab_pkg::ST_UNKNOWN;
                else begin
                  bvalid[bhit] <= 1'b0;
                  bytes_in_use <= bytes_in_use - 40'(bhit_size);
                end
              end else if (fn == bab_pkg::FN_REALLOC && r.address != '0 && !bhit_ok)
                status <= bab_pkg::ST_UNKNOWN;
              else if (fn == bab_pkg::FN_REALLOC && r.address != '0 &&
                       r.size <= bhit_size) begin
                bsize[bhit] <= r.size;
                bytes_in_use <= bytes_in_use - 40'(bhit_size) + 40'(r.size);
                res_addr <= r.address;
              end else if (fn != bab_pkg::FN_CALLOC && size_bad)
                status <= bab_pkg::ST_SIZE;
              else if (!bfree_ok) status <= bab_pkg::ST_FULL;
              else if (bump_end > 49'hFFFF_FFFF_FFFF) status <= bab_pkg::ST_SIZE;
              else begin
                next_free_address <= bump_end[47:0];
                bvalid[bfree] <= 1'b1;
                baddr[bfree] <= bump_a[47:0];
                bsize[bfree] <= eff_size[31:0];
                res_addr <= bump_a[47:0];
                bytes_in_use <= bytes_in_use + 40'(eff_size);
                grow <= (fn == bab_pkg::FN_REALLOC) && (r.address != '0);
              end
            end
            bab_pkg::FN_FREE: begin
              if (r.address != '0) begin
                if (!bhit_ok) status <= bab_pkg::ST_UNKNOWN;
                else begin
                  bvalid[bhit] <= 1'b0;
                  bytes_in_use <= bytes_in_use - 40'(bhit_size);
                end
              end
            end
            bab_pkg::FN_MMAP: begin
              if (size_bad) status <= bab_pkg::ST_SIZE;
              else if (!rfree_ok) status <= bab_pkg::ST_FULL;
              else if (is_fixed && fix_end > 49'h1_0000_0000_0000) status <= bab_pkg::ST_SIZE;
              else if (is_fixed && ovl) status <= bab_pkg::ST_OVERLAP;
              else if (!is_fixed && bump_end > 49'hFFFF_FFFF_FFFF) status <= bab_pkg::ST_SIZE;
              else begin
                if (!is_fixed) next_free_address <= bump_end[47:0];
                rvalid[rfree] <= 1'b1;
                raddr[rfree] <= is_fixed ? r.address : bump_a[47:0];
                rsize[rfree] <= pages[31:0];
                res_addr <= is_fixed ? r.address : bump_a[47:0];
                bytes_in_use <= bytes_in_use + 40'(pages);
              end
            end
            bab_pkg::FN_MUNMAP: begin
              if (!rhit_ok) status <= bab_pkg::ST_NOTFOUND;
              else begin
                rvalid[rhit] <= 1'b0;
                bytes_in_use <= bytes_in_use - 40'(rsize[rhit]);
              end
            end
            default: if (bhit_ok) res_bsize <= bhit_size;
          endcase
        end
        S_MAP: begin   // peak sees the total before a moved block's old copy is freed
          if (bytes_in_use > bytes_peak) bytes_peak <= bytes_in_use;
          if (grow) begin
            bvalid[bhit] <= 1'b0;
            bytes_in_use <= bytes_in_use - 40'(bhit_size);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          rsp.status <= status;
          rsp.result_address <= (status == bab_pkg::ST_OK) ? res_addr : '0;
          rsp.block_size <= res_bsize;
          rsp.total_in_use <= bytes_in_use;
          rsp.peak_in_use <= bytes_peak;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_peak: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> bytes_peak >= bytes_in_use) else $error("peak below total");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(state == S_IDLE)) else $error("done without request");
  a_nf: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> next_free_address >= $past(next_free_address))
    else $error("bump moved down");
`endif

endmodule

>>> tb/sv/bab_checker.sv
module bab_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  bab_pkg::req_t   req,
  input  logic            done,
  input  bab_pkg::rsp_t   rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              errors,
  output int              pending
);

  localparam logic [47:0] ADDR_TOP = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    bit        live;
    bit [47:0] base;
    bit [31:0] len;
  } slot_t;

  bit [31:0] max_alloc;
  bit [47:0] bump_ptr;
  bit [39:0] in_use;
  bit [39:0] in_use_peak;
  slot_t     blocks[bab_pkg::BLOCK_SLOTS];
  slot_t     regions[bab_pkg::REGION_SLOTS];
  bab_pkg::rsp_t expected_rsps[$];

  function automatic int free_block_slot();
    for (int i = 0; i < bab_pkg::BLOCK_SLOTS; i++) if (!blocks[i].live) return i;
    return -1;
  endfunction

  function automatic int free_region_slot();
    for (int i = 0; i < bab_pkg::REGION_SLOTS; i++) if (!regions[i].live) return i;
    return -1;
  endfunction

  function automatic int lookup_block(bit [47:0] a);
    for (int i = 0; i < bab_pkg::BLOCK_SLOTS; i++)
      if (blocks[i].live && blocks[i].base == a) return i;
    return -1;
  endfunction

  function automatic void charge(bit [39:0] n);
    in_use = in_use + n;
    if (in_use > in_use_peak) in_use_peak = in_use;
  endfunction

  // align is zero or a power of two
  function automatic bab_pkg::status_t bump_alloc(bit [63:0] n, bit [63:0] align,
                                                  output bit [47:0] got);
    int s;
    bit [63:0] a, e;
    s = free_block_slot();
    got = '0;
    if (s < 0) return bab_pkg::ST_FULL;
    a = bump_ptr;
    if (align != 0) a = (a + align - 1) & ~(align - 1);
    e = a + n;
    if (e > ADDR_TOP) return bab_pkg::ST_SIZE;
    bump_ptr = e[47:0];
    blocks[s].live = 1; blocks[s].base = a[47:0]; blocks[s].len = n[31:0];
    charge(n[39:0]);
    got = a[47:0];
    return bab_pkg::ST_OK;
  endfunction

  function automatic bab_pkg::status_t plain_alloc(bit [63:0] n, output bit [47:0] got);
    got = '0;
    if (n == 0 || n > max_alloc) return bab_pkg::ST_SIZE;
    return bump_alloc(n, 0, got);
  endfunction

  function automatic bab_pkg::status_t release_block(bit [47:0] a);
    int b;
    if (a == 0) return bab_pkg::ST_OK;
    b = lookup_block(a);
    if (b < 0) return bab_pkg::ST_UNKNOWN;
    in_use = in_use - blocks[b].len;
    blocks[b].live = 0;
    return bab_pkg::ST_OK;
  endfunction

  function automatic bab_pkg::rsp_t serve(bab_pkg::req_t r);
    bab_pkg::rsp_t o;
    bab_pkg::status_t st;
    bit [47:0] got;
    bit [63:0] pages, a, e, al;
    int b, s;
    st = bab_pkg::ST_OK; got = '0;
    o = '0;
    al = r.alignment;
    case (bab_pkg::func_t'(r.func))
      bab_pkg::FN_MALLOC: st = plain_alloc(r.size, got);
      bab_pkg::FN_ALIGNED: begin
        if (al == 0 || (al & (al - 1)) != 0) st = bab_pkg::ST_ALIGN;
        else if (r.size == 0 || r.size > max_alloc) st = bab_pkg::ST_SIZE;
        else st = bump_alloc(r.size, al, got);
      end
      bab_pkg::FN_CALLOC: begin
        if (r.count > 0 && r.size > max_alloc / r.count) st = bab_pkg::ST_SIZE;
        else st = plain_alloc(64'(r.count) * 64'(r.size), got);
      end
      bab_pkg::FN_REALLOC: begin
        if (r.address == 0) st = plain_alloc(r.size, got);
        else if (r.size == 0) st = release_block(r.address);
        else begin
          b = lookup_block(r.address);
          if (b < 0) st = bab_pkg::ST_UNKNOWN;
          else if (r.size <= blocks[b].len) begin
            in_use = in_use - blocks[b].len + r.size;
            blocks[b].len = r.size;
            got = r.address;
          end else begin
            st = plain_alloc(r.size, got);
            if (st == bab_pkg::ST_OK) void'(release_block(r.address));
          end
        end
      end
      bab_pkg::FN_FREE: st = release_block(r.address);
      bab_pkg::FN_MMAP: begin
        if (r.size == 0 || r.size > max_alloc) st = bab_pkg::ST_SIZE;
        else begin
          pages = ((64'(r.size) + bab_pkg::PAGE_BYTES - 1) / bab_pkg::PAGE_BYTES) *
                  bab_pkg::PAGE_BYTES;
          s = free_region_slot();
          if (s < 0) st = bab_pkg::ST_FULL;
          else begin
            if (r.address != 0 && r.fixed_map) begin
              a = r.address; e = a + pages;
              if (e > 64'(ADDR_TOP) + 1) st = bab_pkg::ST_SIZE;
              else
                for (int i = 0; i < bab_pkg::REGION_SLOTS; i++)
                  if (regions[i].live && regions[i].base < e &&
                      a < 64'(regions[i].base) + regions[i].len)
                    st = bab_pkg::ST_OVERLAP;
            end else begin
              a = (64'(bump_ptr) + bab_pkg::PAGE_BYTES - 1) &
                  ~64'(bab_pkg::PAGE_BYTES - 1);
              e = a + pages;
              if (e > ADDR_TOP) st = bab_pkg::ST_SIZE;
              else bump_ptr = e[47:0];
            end
            if (st == bab_pkg::ST_OK) begin
              regions[s].live = 1; regions[s].base = a[47:0];
              regions[s].len = pages[31:0];
              charge(pages[39:0]);
              got = a[47:0];
            end
          end
        end
      end
      bab_pkg::FN_MUNMAP: begin
        st = bab_pkg::ST_NOTFOUND;
        for (int i = 0; i < bab_pkg::REGION_SLOTS; i++)
          if (st == bab_pkg::ST_NOTFOUND && regions[i].live &&
              regions[i].base == r.address) begin
            in_use = in_use - regions[i].len;
            regions[i].live = 0;
            st = bab_pkg::ST_OK;
          end
      end
      default: begin
        b = lookup_block(r.address);
        if (b >= 0) o.block_size = blocks[b].len;
      end
    endcase
    if (st != bab_pkg::ST_OK) got = '0;
    o.status = st;
    o.result_address = got;
    o.total_in_use = in_use;
    o.peak_in_use = in_use_peak;
    return o;
  endfunction

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    bab_pkg::rsp_t want;
    if (rst) begin
      max_alloc <= 32'hFFFF_FFFF;
      bump_ptr = bab_pkg::HEAP_BASE;
      in_use = '0;
      in_use_peak = '0;
      foreach (blocks[i]) blocks[i].live = 0;
      foreach (regions[i]) regions[i].live = 0;
      expected_rsps.delete();
      errors <= 0;
    end else begin
      // response first: a new beat cannot complete in its own cycle
      if (done) begin
        if (expected_rsps.size() == 0) begin
          if (errors < 10) $display("unexpected response %p", rsp);
          errors <= errors + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status || rsp.result_address !== want.result_address ||
              rsp.block_size !== want.block_size ||
              rsp.total_in_use !== want.total_in_use ||
              rsp.peak_in_use !== want.peak_in_use) begin
            if (errors < 10) $display("mismatch: expected %p actual %p", want, rsp);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) expected_rsps.insert(expected_rsps.size(), serve(req));
      if (psel && penable && pwrite && pready && paddr == bab_pkg::REG_MAX_ALLOC)
        max_alloc <= pwdata;
    end
  end
endmodule

>>> tb/sv/bump_allocator_with_block_table_tb.sv
module bump_allocator_with_block_table_tb;

  logic clk, rst, start, busy, done;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  bab_pkg::req_t req;
  bab_pkg::rsp_t rsp;
  int errors, pending;
  bit [47:0] handed[$];

  bump_allocator_with_block_table dut (.*);
  bab_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic reg_write(logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= bab_pkg::REG_MAX_ALLOC; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic issue(bab_pkg::func_t f, logic [47:0] a, logic [31:0] s, logic [31:0] c,
                       logic [31:0] al, logic fx);
    repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15)) @(posedge clk);
    req <= '{func: f, address: a, size: s, count: c, alignment: al, fixed_map: fx};
    start <= 1;
    do @(posedge clk); while (busy);
    start <= 0;
    // remember addresses for later free/realloc/query traffic
    @(posedge clk);
    while (!done) @(posedge clk);
    if (rsp.result_address != 0) handed.insert(handed.size(), rsp.result_address);
    if (handed.size() > 80) void'(handed.pop_front());
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4);
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  function automatic logic [47:0] rand_addr();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 48'({$urandom, $urandom});
      2: return 48'hFFFF_FFFF_F000;
      default: return handed.size() ? handed[$urandom_range(0, handed.size() - 1)]
                                    : 48'h100000;
    endcase
  endfunction

  task automatic random_phase(int n);
    bab_pkg::func_t f;
    logic [31:0] al;
    for (int i = 0; i < n; i++) begin
      f = bab_pkg::func_t'($urandom_range(0, 7));
      al = $urandom_range(0, 3) == 0 ? $urandom : 32'd1 << $urandom_range(0, 31);
      issue(f, rand_addr(), rand_size(),
            $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8), al,
            1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst = 1; start = 0; req = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed
    issue(bab_pkg::FN_MALLOC, 0, 0, 0, 0, 0);
    issue(bab_pkg::FN_MALLOC, 0, 32'hFFFF_FFFF, 0, 0, 0);
    issue(bab_pkg::FN_MALLOC, 0, 100, 0, 0, 0);
    issue(bab_pkg::FN_ALIGNED, 0, 16, 0, 0, 0);
    issue(bab_pkg::FN_ALIGNED, 0, 16, 0, 3, 0);
    issue(bab_pkg::FN_ALIGNED, 0, 16, 0, 32'h8000_0000, 0);
    issue(bab_pkg::FN_CALLOC, 0, 32'hFFFF_FFFF, 2, 0, 0);
    issue(bab_pkg::FN_CALLOC, 0, 5, 0, 0, 0);
    issue(bab_pkg::FN_CALLOC, 0, 8, 12, 0, 0);
    issue(bab_pkg::FN_REALLOC, 0, 40, 0, 0, 0);
    issue(bab_pkg::FN_REALLOC, handed[0], 10, 0, 0, 0);
    issue(bab_pkg::FN_REALLOC, handed[0], 500, 0, 0, 0);
    issue(bab_pkg::FN_REALLOC, 48'h1234, 5, 0, 0, 0);
    issue(bab_pkg::FN_REALLOC, handed[handed.size() - 1], 0, 0, 0, 0);
    issue(bab_pkg::FN_FREE, 0, 0, 0, 0, 0);
    issue(bab_pkg::FN_FREE, 48'h5, 0, 0, 0, 0);
    issue(bab_pkg::FN_MMAP, 0, 1, 0, 0, 0);
    issue(bab_pkg::FN_MMAP, 48'h4000_0000, 8192, 0, 0, 1);
    issue(bab_pkg::FN_MMAP, 48'h4000_1000, 10, 0, 0, 1);
    issue(bab_pkg::FN_MMAP, 48'hFFFF_FFFF_F000, 4097, 0, 0, 1);
    issue(bab_pkg::FN_MMAP, 48'hFFFF_FFFF_F000, 4096, 0, 0, 1);
    issue(bab_pkg::FN_MUNMAP, 48'h4000_0000, 0, 0, 0, 0);
    issue(bab_pkg::FN_MUNMAP, 48'h4000_0000, 0, 0, 0, 0);
    issue(bab_pkg::FN_QUERY, handed[1], 0, 0, 0, 0);
    issue(bab_pkg::FN_QUERY, 48'h7, 0, 0, 0, 0);
    settle();
    reg_write(32'd1);
    random_phase(100);
    settle();
    reg_write(32'd5000);
    random_phase(500);
    settle();
    reg_write($urandom);
    random_phase(200);
    settle();
    reg_write(32'hFFFF_FFFF);
    random_phase(500);
    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
